// File: sv/hkra_pkg.sv
package hkra_pkg;

  localparam int unsigned KEY_COUNT = 6;
  localparam int unsigned KEY_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned SEL_W = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [KEY_W-1:0] SHIFT_MASK = 8'h22;
  localparam logic [KEY_W-1:0] CODE_LIMIT = 8'h40;

  localparam logic [CHAR_W-1:0] CH_CR = 7'h0d;
  localparam logic [CHAR_W-1:0] CH_ESC = 7'h1b;
  localparam logic [CHAR_W-1:0] CH_DEL = 7'h7f;
  localparam logic [CHAR_W-1:0] CH_TAB = 7'h09;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_RD_WAIT,
    ST_EMIT
  } st_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t                                op;
    logic [KEY_COUNT-1:0]               mask;
    logic [KEY_COUNT-1:0][CHAR_W-1:0]   chars;
  } entry_t;

  // US layout, usage codes below CODE_LIMIT
  function automatic logic [CHAR_W-1:0] key_char(input logic [5:0] code, input logic shift);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (code >= 6'd4 && code <= 6'd29) begin
      ch = (shift ? 7'h41 : 7'h61) + CHAR_W'(code - 6'd4);
    end else begin
      unique case (code)
        6'd30: ch = shift ? 7'h21 : 7'h31;
        6'd31: ch = shift ? 7'h40 : 7'h32;
        6'd32: ch = shift ? 7'h23 : 7'h33;
        6'd33: ch = shift ? 7'h24 : 7'h34;
        6'd34: ch = shift ? 7'h25 : 7'h35;
        6'd35: ch = shift ? 7'h5e : 7'h36;
        6'd36: ch = shift ? 7'h26 : 7'h37;
        6'd37: ch = shift ? 7'h2a : 7'h38;
        6'd38: ch = shift ? 7'h28 : 7'h39;
        6'd39: ch = shift ? 7'h29 : 7'h30;
        6'd40: ch = CH_CR;
        6'd41: ch = CH_ESC;
        6'd42: ch = CH_DEL;
        6'd43: ch = CH_TAB;
        6'd44: ch = 7'h20;
        6'd45: ch = shift ? 7'h5f : 7'h2d;
        6'd46: ch = shift ? 7'h2b : 7'h3d;
        6'd47: ch = shift ? 7'h7b : 7'h5b;
        6'd48: ch = shift ? 7'h7d : 7'h5d;
        6'd49: ch = shift ? 7'h7c : 7'h5c;
        6'd51: ch = shift ? 7'h3a : 7'h3b;
        6'd52: ch = shift ? 7'h22 : 7'h27;
        6'd53: ch = shift ? 7'h7e : 7'h60;
        6'd54: ch = shift ? 7'h3c : 7'h2c;
        6'd55: ch = shift ? 7'h3e : 7'h2e;
        6'd56: ch = shift ? 7'h3f : 7'h2f;
        default: ch = '0;
      endcase
    end
    return ch;
  endfunction

endpackage

// File: sv/hkra_ram.sv
module hkra_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/hkra_front.sv
module hkra_front (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic                                         in_opcode,
  input  logic [hkra_pkg::KEY_W-1:0]                   in_modifier,
  input  logic [hkra_pkg::KEY_COUNT-1:0][hkra_pkg::KEY_W-1:0] keys,
  input  logic                                         q_full,
  output logic                                         q_push,
  output hkra_pkg::entry_t                             q_entry
);

  logic [hkra_pkg::KEY_COUNT-1:0][hkra_pkg::KEY_W-1:0] prev_r;
  logic [hkra_pkg::KEY_COUNT-1:0][hkra_pkg::KEY_W-1:0] prev_nxt;
  logic                                               shift;
  logic [hkra_pkg::KEY_COUNT-1:0]                     held;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign shift    = |(in_modifier & hkra_pkg::SHIFT_MASK);

  always_comb begin
    q_entry.op = hkra_pkg::op_t'(in_opcode);
    for (int i = 0; i < hkra_pkg::KEY_COUNT; i++) begin
      held[i] = 1'b0;
      for (int j = 0; j < hkra_pkg::KEY_COUNT; j++) begin
        if (prev_r[j] == keys[i]) begin
          held[i] = 1'b1;
        end
      end
      q_entry.chars[i] = hkra_pkg::key_char(keys[i][5:0], shift);
      q_entry.mask[i]  = (keys[i] != '0) && (keys[i] < hkra_pkg::CODE_LIMIT) &&
                         !held[i] && (q_entry.chars[i] != '0);
    end
  end

  // keys of an accepted report become the held set
  always_comb begin
    prev_nxt = prev_r;
    if (q_push && q_entry.op == hkra_pkg::OP_REPORT) begin
      prev_nxt = keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

// File: sv/hkra_queue.sv
module hkra_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hkra_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output hkra_pkg::entry_t head
);

  localparam int unsigned IW = $clog2(hkra_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(hkra_pkg::QUEUE_DEPTH + 1);

  hkra_pkg::entry_t entries_r [hkra_pkg::QUEUE_DEPTH];
  logic [IW-1:0]    wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full       = (count_r == CW'(hkra_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_idx_r];

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    if (push) begin
      wr_idx_nxt = (wr_idx_r == IW'(hkra_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
    end
    if (pop) begin
      rd_idx_nxt = (rd_idx_r == IW'(hkra_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_idx_r] <= push_entry;
    end
  end

endmodule

// File: sv/hkra_back.sv
module hkra_back #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  hkra_pkg::entry_t              q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hkra_pkg::CHAR_W-1:0]   out_char_out,
  output logic                          out_char_valid,
  output logic                          out_available
);

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  hkra_pkg::st_t                                        state_r, state_nxt;
  logic [PW-1:0]                                        wr_r, wr_nxt, wr_inc;
  logic [PW-1:0]                                        rd_r, rd_nxt, rd_inc;
  logic [hkra_pkg::KEY_COUNT-1:0]                       mask_r, mask_nxt;
  logic [hkra_pkg::KEY_COUNT-1:0][hkra_pkg::CHAR_W-1:0] chars_r, chars_nxt;
  logic [hkra_pkg::CHAR_W-1:0]                          res_char_r, res_char_nxt;
  logic                                                 res_valid_r, res_valid_nxt;
  logic                                                 out_valid_r, out_valid_nxt;
  logic [hkra_pkg::CHAR_W-1:0]                          out_char_r, out_char_nxt;
  logic                                                 out_cv_r, out_cv_nxt;
  logic                                                 out_av_r, out_av_nxt;
  logic [hkra_pkg::SEL_W-1:0]                           sel;
  logic                                                 ram_we, ram_re;
  logic [hkra_pkg::CHAR_W-1:0]                          ram_rdata;

  assign wr_inc = (wr_r == PW'(RING_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == PW'(RING_DEPTH - 1)) ? '0 : rd_r + 1'b1;

  // lowest pending key goes first
  always_comb begin
    sel = '0;
    for (int i = hkra_pkg::KEY_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = hkra_pkg::SEL_W'(i);
      end
    end
  end

  hkra_ram #(
    .WIDTH (hkra_pkg::CHAR_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_r),
    .wdata (chars_r[sel]),
    .re    (ram_re),
    .raddr (rd_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    wr_nxt        = wr_r;
    rd_nxt        = rd_r;
    mask_nxt      = mask_r;
    chars_nxt     = chars_r;
    res_char_nxt  = res_char_r;
    res_valid_nxt = res_valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_cv_nxt    = out_cv_r;
    out_av_nxt    = out_av_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      hkra_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          res_char_nxt  = '0;
          res_valid_nxt = 1'b0;
          if (q_head.op == hkra_pkg::OP_REPORT) begin
            mask_nxt  = q_head.mask;
            chars_nxt = q_head.chars;
            state_nxt = hkra_pkg::ST_PUSH;
          end else if (wr_r == rd_r) begin
            state_nxt = hkra_pkg::ST_EMIT;
          end else begin
            ram_re    = 1'b1;
            state_nxt = hkra_pkg::ST_RD_WAIT;
          end
        end
      end
      hkra_pkg::ST_PUSH: begin
        if (mask_r == '0) begin
          state_nxt = hkra_pkg::ST_EMIT;
        end else begin
          // full ring drops the character
          if (wr_inc != rd_r) begin
            ram_we = 1'b1;
            wr_nxt = wr_inc;
          end
          mask_nxt[sel] = 1'b0;
        end
      end
      hkra_pkg::ST_RD_WAIT: begin
        res_char_nxt  = ram_rdata;
        res_valid_nxt = 1'b1;
        rd_nxt        = rd_inc;
        state_nxt     = hkra_pkg::ST_EMIT;
      end
      hkra_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = res_char_r;
          out_cv_nxt    = res_valid_r;
          out_av_nxt    = (wr_r != rd_r);
          state_nxt     = hkra_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hkra_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hkra_pkg::ST_IDLE;
      wr_r        <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r      <= mask_nxt;
    chars_r     <= chars_nxt;
    res_char_r  <= res_char_nxt;
    res_valid_r <= res_valid_nxt;
    out_char_r  <= out_char_nxt;
    out_cv_r    <= out_cv_nxt;
    out_av_r    <= out_av_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char_out   = out_char_r;
  assign out_char_valid = out_cv_r;
  assign out_available  = out_av_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wr_r} < (PW + 1)'(RING_DEPTH)) && ({1'b0, rd_r} < (PW + 1)'(RING_DEPTH)))
    else $error("ring pointer out of range");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == hkra_pkg::ST_EMIT))
    else $error("result loaded outside emit");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (wr_r != rd_r) && $stable(rd_r))
    else $error("ring write overran read pointer");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != hkra_pkg::ST_IDLE)
    else $error("queue popped without leaving idle");

endmodule

// File: sv/hid_keyboard_report_to_ascii.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_opcode, in_modifier, in_key0..in_key5
// out_    | output    | out_valid/out_stall| out_char_out, out_char_valid, out_available
//
// A read on a non-empty ring passes through a wait state, as the ring memory read
// is registered; a report walks its new mappable keys in the push state, the back
// end writing one character per cycle into the ring's separate write port.
// The front end classifies a report in the cycle it is accepted, so up to two
// items can wait in the queue while the back end works.
// Reset: rst_n is synchronous, active low; clears pointers, held keys, queue and
// output valid. The character ring itself is not cleared.
// Stalls: in_stall rises only when the two-entry queue is full; out_stall holds the
// output register and the back end waits in its emit state.
module hid_keyboard_report_to_ascii #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_modifier,
  input  logic [7:0] in_key0,
  input  logic [7:0] in_key1,
  input  logic [7:0] in_key2,
  input  logic [7:0] in_key3,
  input  logic [7:0] in_key4,
  input  logic [7:0] in_key5,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char_out,
  output logic       out_char_valid,
  output logic       out_available
);

  // Front: compares the six codes against the held set, looks up characters
  // and builds a push mask; the held set updates on each accepted report.
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  hkra_pkg::entry_t q_in;
  hkra_pkg::entry_t q_head;

  hkra_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_modifier (in_modifier),
    .keys        ({in_key5, in_key4, in_key3, in_key2, in_key1, in_key0}),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_in)
  );

  // Short queue decouples classification from ring access.
  hkra_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Back: owns the ring and its pointers, walks the push mask one key per
  // cycle, serves reads and drives the output register.
  hkra_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_char_valid (out_char_valid),
    .out_available  (out_available)
  );

endmodule
